/* rtl/plcs_pkg.sv */
// ----------------------------------------------------------------------------
// Pump and lamp cycle sequencer package
// Shared widths, phase codes, configuration indexes and bundle types.
// ----------------------------------------------------------------------------
package plcs_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 3;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [1:0]             phase_t;

	localparam phase_t PH_REST  = 2'd0;
	localparam phase_t PH_PUMP  = 2'd1;
	localparam phase_t PH_SLEEP = 2'd2;
	localparam phase_t PH_GUARD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_REST    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LED     = 3'd4;

	typedef struct packed {
		logic [15:0] rest_seconds;
		logic [15:0] run_seconds;
		logic [7:0]  protect_seconds;
		logic [3:0]  settle_ticks;
		logic [15:0] led_seconds;
	} cfg_t;

	// Next-state view of one settle filter.
	typedef struct packed {
		logic edge_seen;
		logic level;
		logic pending;
	} sense_t;

	typedef struct packed {
		logic   pump_drive;
		logic   lamp_drive;
		phase_t phase_now;
	} seq_out_t;

	function automatic timer_t timer_inc(timer_t t);
		timer_inc = (t == '1) ? t : t + timer_t'(1);
	endfunction

endpackage

/* rtl/pump_lamp_cycle_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Pump and lamp cycle sequencer
// Stream wrapper with configuration registers, input and result registers.
// A word accepted into the input register has its result registered in the result register.
// Throughput: one word per clock cycle when the result side keeps tready high.
// The limit is the single state update per word between the two registers.
// Reset: arst_n low clears the filter and sequencer state, empties both registers and
// restores the default configuration; the input register is ready for words once reset is released.
// ----------------------------------------------------------------------------
module pump_lamp_cycle_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // light_raw, flow_raw
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // pump_drive, lamp_drive,
	                                                         // phase_now[1:0],
	                                                         // light_filtered, flow_filtered
	input  logic                              cfg_we,
	input  logic [plcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [plcs_pkg::CFG_WIDTH-1:0]    cfg_data
);

	plcs_pkg::cfg_t     cfg_q;
	logic               valid_s1;
	logic               light_s1;
	logic               flow_s1;
	logic               adv;
	logic               filter_en;
	plcs_pkg::sense_t   light_s;
	plcs_pkg::sense_t   flow_s;
	plcs_pkg::seq_out_t seq;
	logic               out_valid_q;
	logic [7:0]         out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_seconds    <= 16'd900;
			cfg_q.run_seconds     <= 16'd600;
			cfg_q.protect_seconds <= 8'd20;
			cfg_q.settle_ticks    <= 4'd1;
			cfg_q.led_seconds     <= 16'd3600;
		end else if (cfg_we) begin
			case (cfg_index)
				plcs_pkg::CFG_REST:    cfg_q.rest_seconds    <= cfg_data;
				plcs_pkg::CFG_RUN:     cfg_q.run_seconds     <= cfg_data;
				plcs_pkg::CFG_PROTECT: cfg_q.protect_seconds <= cfg_data[7:0];
				plcs_pkg::CFG_SETTLE:  cfg_q.settle_ticks    <= cfg_data[3:0];
				plcs_pkg::CFG_LED:     cfg_q.led_seconds     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			light_s1 <= s_axis_tdata[0];
			flow_s1  <= s_axis_tdata[1];
		end
	end

	plcs_filter u_light (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.raw          (light_s1),
		.filter_en    (filter_en),
		.settle_ticks (cfg_q.settle_ticks),
		.sense        (light_s)
	);

	plcs_filter u_flow (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.raw          (flow_s1),
		.filter_en    (filter_en),
		.settle_ticks (cfg_q.settle_ticks),
		.sense        (flow_s)
	);

	plcs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.light_raw (light_s1),
		.cfg       (cfg_q),
		.light_s   (light_s),
		.flow_s    (flow_s),
		.filter_en (filter_en),
		.seq       (seq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {2'b00, flow_s.level, light_s.level, seq.phase_now,
				seq.lamp_drive, seq.pump_drive};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/plcs_filter.sv */
// ----------------------------------------------------------------------------
// Sensor settle filter
// Captures level changes and accepts a new level once it has settled.
// ----------------------------------------------------------------------------
module plcs_filter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             raw,
	input  logic             filter_en,
	input  logic [3:0]       settle_ticks,
	output plcs_pkg::sense_t sense
);

	logic       last_q;
	logic       pend_q;
	logic [3:0] cnt_q;
	logic       level_q;

	logic       edge_c;
	logic       pend_e;
	logic [3:0] cnt_e;
	logic       pend_n;
	logic [3:0] cnt_n;
	logic       level_n;

	always_comb begin
		edge_c  = (raw != last_q);
		pend_e  = edge_c ? 1'b1 : pend_q;
		cnt_e   = edge_c ? 4'd0 : cnt_q;
		pend_n  = pend_e;
		cnt_n   = cnt_e;
		level_n = level_q;
		if (filter_en && pend_e) begin
			if (cnt_e >= settle_ticks) begin
				level_n = raw;
				pend_n  = 1'b0;
				cnt_n   = 4'd0;
			end else begin
				cnt_n = cnt_e + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b1;
			pend_q  <= 1'b1;
			cnt_q   <= 4'd0;
			level_q <= 1'b1;
		end else if (adv) begin
			last_q  <= raw;
			pend_q  <= pend_n;
			cnt_q   <= cnt_n;
			level_q <= level_n;
		end
	end

	assign sense.edge_seen = edge_c;
	assign sense.level     = level_n;
	assign sense.pending   = pend_n;

endmodule

/* rtl/plcs_core.sv */
// ----------------------------------------------------------------------------
// Pump and lamp phase sequencer
// Phase, phase timer, lamp timer and sleep request for one tick.
// ----------------------------------------------------------------------------
module plcs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               light_raw,
	input  plcs_pkg::cfg_t     cfg,
	input  plcs_pkg::sense_t   light_s,
	input  plcs_pkg::sense_t   flow_s,
	output logic               filter_en,
	output plcs_pkg::seq_out_t seq
);

	plcs_pkg::phase_t phase_q;
	plcs_pkg::timer_t phase_timer_q;
	logic             lamp_on_q;
	plcs_pkg::timer_t lamp_timer_q;
	logic             sleep_req_q;

	plcs_pkg::phase_t phase_n;
	plcs_pkg::timer_t phase_timer_n;
	logic             lamp_on_n;
	plcs_pkg::timer_t lamp_timer_n;
	logic             sleep_req_n;
	plcs_pkg::timer_t pt_inc;
	logic             stop;

	assign filter_en = (phase_q == plcs_pkg::PH_REST) || (phase_q == plcs_pkg::PH_PUMP);
	assign pt_inc    = plcs_pkg::timer_inc(phase_timer_q);

	always_comb begin
		phase_n       = phase_q;
		phase_timer_n = phase_timer_q;
		lamp_on_n     = lamp_on_q;
		lamp_timer_n  = lamp_timer_q;
		sleep_req_n   = sleep_req_q;
		stop          = 1'b0;

		if (lamp_on_q) begin
			lamp_timer_n = plcs_pkg::timer_inc(lamp_timer_q);
			if (32'(lamp_timer_n) > 32'(cfg.led_seconds)) begin
				sleep_req_n = 1'b1;
			end
		end

		case (phase_q)
			plcs_pkg::PH_REST: begin
				phase_timer_n = pt_inc;
				if (32'(pt_inc) >= 32'(cfg.rest_seconds)) begin
					if (!lamp_on_q && !light_s.level) begin
						lamp_on_n    = 1'b1;
						lamp_timer_n = '0;
					end
					phase_n       = plcs_pkg::PH_PUMP;
					phase_timer_n = '0;
				end
			end
			plcs_pkg::PH_PUMP: begin
				stop = (32'(phase_timer_q) > 32'(cfg.run_seconds)) ||
					((32'(phase_timer_q) > 32'(cfg.protect_seconds)) &&
					 (!flow_s.level || flow_s.pending));
				phase_timer_n = pt_inc;
				if (stop) begin
					phase_timer_n = '0;
					if (sleep_req_n) begin
						lamp_on_n = 1'b0;
						phase_n   = plcs_pkg::PH_SLEEP;
					end else begin
						phase_n = plcs_pkg::PH_REST;
					end
				end
			end
			plcs_pkg::PH_SLEEP: begin
				if (light_s.edge_seen || flow_s.edge_seen) begin
					phase_n       = plcs_pkg::PH_GUARD;
					phase_timer_n = '0;
				end
			end
			default: begin
				phase_timer_n = pt_inc;
				if (32'(pt_inc) >= 32'(cfg.protect_seconds)) begin
					phase_timer_n = '0;
					if (light_raw) begin
						sleep_req_n = 1'b0;
						phase_n     = plcs_pkg::PH_REST;
					end else begin
						phase_n = plcs_pkg::PH_SLEEP;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= plcs_pkg::PH_REST;
			phase_timer_q <= '0;
			lamp_on_q     <= 1'b0;
			lamp_timer_q  <= '0;
			sleep_req_q   <= 1'b0;
		end else if (adv) begin
			phase_q       <= phase_n;
			phase_timer_q <= phase_timer_n;
			lamp_on_q     <= lamp_on_n;
			lamp_timer_q  <= lamp_timer_n;
			sleep_req_q   <= sleep_req_n;
		end
	end

	assign seq.pump_drive = (phase_n == plcs_pkg::PH_PUMP);
	assign seq.lamp_drive = lamp_on_n;
	assign seq.phase_now  = phase_n;

`ifndef SYNTH
	// Every phase change starts the new phase with a cleared timer.
	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_n != phase_q) |=> (phase_timer_q == '0))
		else $error("phase timer not cleared on phase change");

	// The lamp never changes while sleeping or guarding.
	a_lamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (phase_q == plcs_pkg::PH_SLEEP || phase_q == plcs_pkg::PH_GUARD))
		|=> $stable(lamp_on_q))
		else $error("lamp changed outside rest and pumping");

	// Going to sleep always turns the lamp off.
	a_sleep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == plcs_pkg::PH_PUMP && phase_n == plcs_pkg::PH_SLEEP)
		|=> !lamp_on_q)
		else $error("lamp still on after entering sleep");

	// Sleep is entered only with a pending request.
	a_sleep_req: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_n == plcs_pkg::PH_SLEEP && phase_q == plcs_pkg::PH_PUMP)
		|=> sleep_req_q)
		else $error("sleep entered without request");
`endif

endmodule

/* verif/pump_lamp_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump and lamp sequencer checker
// Watches the tick channel, the result channel and the register port, keeps
// its own copy of the filters, the phase machine and the lamp timer, and
// compares each result word field by field with the word predicted for the
// oldest outstanding tick.
// ----------------------------------------------------------------------------
module pump_lamp_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // light_raw, flow_raw
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [7:0]                     m_axis_tdata,  // pump_drive, lamp_drive,
	                                                      // phase_now[1:0],
	                                                      // light_filtered, flow_filtered
	input  logic                           cfg_we,
	input  logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plcs_pkg::CFG_WIDTH-1:0] cfg_data,
	output int                             fail_count,
	output int                             outstanding
);

	typedef struct packed {
		logic       last;
		logic       pending;
		logic [3:0] count;
		logic       level;
	} filter_t;

	// Same bit order as the low six bits of the result word.
	typedef struct packed {
		logic             flow_filtered;
		logic             light_filtered;
		plcs_pkg::phase_t phase_now;
		logic             lamp_drive;
		logic             pump_drive;
	} lamp_word_t;

	logic [15:0]      rest_len;
	logic [15:0]      run_len;
	logic [7:0]       guard_len;
	logic [3:0]       settle_len;
	logic [15:0]      led_len;

	filter_t          light_f;
	filter_t          flow_f;
	plcs_pkg::phase_t phase;
	plcs_pkg::timer_t phase_timer;
	plcs_pkg::timer_t lamp_timer;
	logic             lamp_on;
	logic             sleep_req;

	lamp_word_t       due_words[$];
	int               errors;

	function automatic plcs_pkg::timer_t bump(plcs_pkg::timer_t t);
		return (&t) ? t : t + 1'b1;
	endfunction

	function automatic filter_t sample_raw(filter_t f, logic raw);
		if (raw != f.last) begin
			f.last = raw;
			f.pending = 1'b1;
			f.count = '0;
		end
		return f;
	endfunction

	function automatic filter_t settle_step(filter_t f, logic [3:0] limit);
		if (f.pending) begin
			if (f.count >= limit) begin
				f.level = f.last;
				f.pending = 1'b0;
				f.count = '0;
			end else begin
				f.count = f.count + 1'b1;
			end
		end
		return f;
	endfunction

	function automatic void load_defaults();
		rest_len = 16'd900;
		run_len = 16'd600;
		guard_len = 8'd20;
		settle_len = 4'd1;
		led_len = 16'd3600;
		light_f = '{1'b1, 1'b1, 4'd0, 1'b1};
		flow_f = '{1'b1, 1'b1, 4'd0, 1'b1};
		phase = plcs_pkg::PH_REST;
		phase_timer = '0;
		lamp_on = 1'b0;
		lamp_timer = '0;
		sleep_req = 1'b0;
	endfunction

	function automatic lamp_word_t advance_tick(logic light_raw, logic flow_raw);
		logic       light_edge;
		logic       flow_edge;
		logic       stop_pump;
		lamp_word_t w;
		light_edge = light_raw != light_f.last;
		flow_edge = flow_raw != flow_f.last;
		light_f = sample_raw(light_f, light_raw);
		flow_f = sample_raw(flow_f, flow_raw);
		if (lamp_on) begin
			lamp_timer = bump(lamp_timer);
			if (lamp_timer > led_len) begin
				sleep_req = 1'b1;
			end
		end
		case (phase)
		plcs_pkg::PH_REST: begin
			light_f = settle_step(light_f, settle_len);
			flow_f = settle_step(flow_f, settle_len);
			phase_timer = bump(phase_timer);
			if (phase_timer >= rest_len) begin
				if (!lamp_on && !light_f.level) begin
					lamp_on = 1'b1;
					lamp_timer = '0;
				end
				phase = plcs_pkg::PH_PUMP;
				phase_timer = '0;
			end
		end
		plcs_pkg::PH_PUMP: begin
			light_f = settle_step(light_f, settle_len);
			flow_f = settle_step(flow_f, settle_len);
			stop_pump = (phase_timer > run_len) ||
				(phase_timer > guard_len && (!flow_f.level || flow_f.pending));
			phase_timer = bump(phase_timer);
			if (stop_pump) begin
				phase_timer = '0;
				if (sleep_req) begin
					lamp_on = 1'b0;
					phase = plcs_pkg::PH_SLEEP;
				end else begin
					phase = plcs_pkg::PH_REST;
				end
			end
		end
		plcs_pkg::PH_SLEEP: begin
			if (light_edge || flow_edge) begin
				phase = plcs_pkg::PH_GUARD;
				phase_timer = '0;
			end
		end
		default: begin
			phase_timer = bump(phase_timer);
			if (phase_timer >= guard_len) begin
				phase_timer = '0;
				if (light_raw) begin
					sleep_req = 1'b0;
					phase = plcs_pkg::PH_REST;
				end else begin
					phase = plcs_pkg::PH_SLEEP;
				end
			end
		end
		endcase
		w.pump_drive = (phase == plcs_pkg::PH_PUMP);
		w.lamp_drive = lamp_on;
		w.phase_now = phase;
		w.light_filtered = light_f.level;
		w.flow_filtered = flow_f.level;
		return w;
	endfunction

	function automatic void check_field(string field, logic [1:0] want, logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lamp_word_t want;
		lamp_word_t got;
		if (!arst_n) begin
			load_defaults();
			due_words.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				plcs_pkg::CFG_REST:    rest_len = cfg_data;
				plcs_pkg::CFG_RUN:     run_len = cfg_data;
				plcs_pkg::CFG_PROTECT: guard_len = cfg_data[7:0];
				plcs_pkg::CFG_SETTLE:  settle_len = cfg_data[3:0];
				plcs_pkg::CFG_LED:     led_len = cfg_data;
				default:               ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[5:0];
				if (due_words.size() == 0) begin
					$display("%0t: result word expected none, got 0x%02h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want = due_words.pop_front();
					check_field("pump_drive", 2'(want.pump_drive), 2'(got.pump_drive));
					check_field("lamp_drive", 2'(want.lamp_drive), 2'(got.lamp_drive));
					check_field("phase_now", want.phase_now, got.phase_now);
					check_field("light_filtered", 2'(want.light_filtered),
						2'(got.light_filtered));
					check_field("flow_filtered", 2'(want.flow_filtered),
						2'(got.flow_filtered));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				due_words.push_back(advance_tick(s_axis_tdata[0], s_axis_tdata[1]));
			end
		end
		fail_count <= errors;
		outstanding <= due_words.size();
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump and lamp sequencer testbench
// Drives one-second tick words with sticky, noisy and broken sensor patterns
// under many register settings, with random gaps and a long result hold-off;
// the checker judges every word.
// ----------------------------------------------------------------------------
module testbench;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata = '0;  // light_raw, flow_raw
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [7:0]                     m_axis_tdata;       // pump_drive, lamp_drive,
	                                                    // phase_now[1:0],
	                                                    // light_filtered, flow_filtered
	logic                           cfg_we = 1'b0;
	logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index = plcs_pkg::CFG_REST;
	logic [plcs_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	int   fail_count;
	int   outstanding;
	bit   calm = 1'b0;
	bit   hold_out = 1'b0;
	int   ticks_sent = 0;
	int   settings_used = 0;
	logic light_now = 1'b1;
	logic flow_now = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pump_lamp_cycle_sequencer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pump_lamp_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [15:0] pick16(int lo, int hi);
		return ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(lo, hi));
	endfunction

	initial begin : result_pacing
		int stall;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				hold_out = 1'b0;
				stall = 400;
			end else begin
				stall = idle_len();
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_tick(input logic light, input logic flow);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, flow, light};
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] rest_s, input logic [15:0] run_s,
			input logic [7:0] guard_s, input logic [3:0] settle_s,
			input logic [15:0] led_s);
		cfg_we <= 1'b1;
		cfg_index <= plcs_pkg::CFG_REST;
		cfg_data <= rest_s;
		@(posedge clk);
		cfg_index <= plcs_pkg::CFG_RUN;
		cfg_data <= run_s;
		@(posedge clk);
		cfg_index <= plcs_pkg::CFG_PROTECT;
		cfg_data <= (plcs_pkg::CFG_WIDTH)'(guard_s);
		@(posedge clk);
		cfg_index <= plcs_pkg::CFG_SETTLE;
		cfg_data <= (plcs_pkg::CFG_WIDTH)'(settle_s);
		@(posedge clk);
		cfg_index <= plcs_pkg::CFG_LED;
		cfg_data <= led_s;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(input int count);
		int light_flip;
		int flow_drop;
		int flow_back;
		bit noisy;
		noisy = $urandom_range(0, 4) == 0;
		light_flip = noisy ? 50 : $urandom_range(1, 20);
		flow_drop = noisy ? 50 : $urandom_range(0, 8);
		flow_back = noisy ? 50 : $urandom_range(15, 60);
		calm = $urandom_range(0, 3) == 0;
		repeat (count) begin
			if ($urandom_range(0, 99) < light_flip) begin
				light_now = !light_now;
			end
			if ($urandom_range(0, 99) < (flow_now ? flow_drop : flow_back)) begin
				flow_now = !flow_now;
			end
			send_tick(light_now, flow_now);
		end
		drain();
		calm = 1'b0;
	endtask

	initial begin : stimulus
		logic [1:0] opening [20];
		int         step;
		int         round;
		// Each entry is {flow, light}: a dark pump run into sleep, a flow edge
		// that wakes to a dark guard and back to sleep, then a light wake.
		opening = '{2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b00,
			2'b00, 2'b00, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11, 2'b11,
			2'b00, 2'b01, 2'b10, 2'b11};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(16'd0, 16'd2, 8'd0, 4'd0, 16'd0);
		foreach (opening[i]) begin
			send_tick(opening[i][0], opening[i][1]);
		end
		drain();

		apply_settings(16'd1, 16'd0, 8'd0, 4'd0, 16'd0);
		random_phase(60);
		apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 4'hF, 16'hFFFF);
		random_phase(40);

		// Wake out of any sleep, then start a dark pump run with the lamp on.
		apply_settings(16'd1, 16'd0, 8'd0, 4'd0, 16'hFFFF);
		for (step = 0; step < 24; step++) begin
			send_tick(step % 4 != 0, 1'b1);
		end
		repeat (6) send_tick(1'b0, 1'b1);
		drain();
		light_now = 1'b0;
		flow_now = 1'b1;

		for (round = 0; round < 15; round++) begin
			apply_settings(pick16(1, 6), pick16(0, 12),
				($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, 8)),
				($urandom_range(0, 9) == 0) ? 4'hF : 4'($urandom_range(0, 3)),
				pick16(0, 40));
			if (round == 2) begin
				hold_out = 1'b1;
			end
			random_phase($urandom_range(50, 80));
		end

		$display("tb: %0d ticks under %0d register settings", ticks_sent, settings_used);
		$display("tb: sensor patterns were sticky, noisy and broken, with a long result hold-off");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
